[hdl/tfe_pkg.sv]
package tfe_pkg;

	// Fixed field widths
	localparam int CELL_W = 17;
	localparam int LEN_W  = 16;

	// Default sizes
	localparam int WORD_COUNT_DEF  = 256;
	localparam int NUM_DOCS_DEF    = 16;
	localparam int MAX_DOC_LEN_DEF = 65535;

	// Cell limits; ONE_FIX is 1.0 in UQ1.16
	localparam logic [CELL_W-1:0] CELL_MAX = 17'h1FFFF;
	localparam logic [CELL_W-1:0] ONE_FIX  = 17'h10000;

	// Quotient bits produced by the divider once the clamp check has passed
	localparam int DIV_STEPS = 17;

	// Request codes
	localparam logic [1:0] REQ_WORD  = 2'd0;
	localparam logic [1:0] REQ_CLOSE = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_SAT   = 2'd2;

	typedef struct packed {
		logic              start;
		logic [CELL_W-1:0] tally;
		logic [LEN_W-1:0]  len;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              clamp;
		logic [CELL_W-1:0] quo;
	} div_rsp_t;

endpackage

[hdl/tfe_if.sv]
// Request channel: one beat per word, close or query item
interface tfe_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] word_index;
	logic [3:0] doc_index;

	modport source (output valid, req_type, word_index, doc_index, input ready);
	modport sink   (input valid, req_type, word_index, doc_index, output ready);
endinterface

// Result channel: one beat per close or query item
interface tfe_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  best_doc;
	logic [16:0] best_tf;

	modport source (output valid, status, best_doc, best_tf, input ready);
	modport sink   (input valid, status, best_doc, best_tf, output ready);
endinterface

[hdl/tfe_div.sv]
// Bit-serial divider for the close normalization: cell * 65536 / len,
// truncated and clamped to 1.0. Cells of twice the length or more clamp
// right away; otherwise one quotient bit is produced per cycle.
module tfe_div
	import tfe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic             clamp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] rem_q;
	logic [CELL_W-1:0] dvd_q;
	logic [CELL_W-1:0] quo_q;

	logic [CELL_W-1:0] trial;
	logic [CELL_W-1:0] diff;
	logic              ge;
	logic              over;

	// One restoring step
	assign trial = {rem_q, dvd_q[CELL_W-1]};
	assign ge    = trial >= {1'b0, len_q};
	assign diff  = trial - {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			clamp_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.tally >= {req.len, 1'b0}) begin
					clamp_q <= 1'b1;
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
				end else begin
					clamp_q <= 1'b0;
					busy_q  <= 1'b1;
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			len_q <= req.len;
			rem_q <= req.tally[CELL_W-1:1];
			dvd_q <= {req.tally[0], {(CELL_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			dvd_q <= {dvd_q[CELL_W-2:0], 1'b0};
			quo_q <= {quo_q[CELL_W-2:0], ge};
		end
	end

	assign over      = clamp_q || (quo_q > ONE_FIX);
	assign rsp.done  = done_q;
	assign rsp.clamp = over;
	assign rsp.quo   = over ? ONE_FIX : quo_q;

endmodule

[hdl/term_frequency_engine.sv]
// Term frequency histogram over a WORD_COUNT x NUM_DOCS store of 17-bit cells
// held in one synchronous RAM (address word * NUM_DOCS + doc). After reset
// the block sweeps the RAM to zero, one cell per cycle, with req.ready low.
// A word beat does one RAM read, then the incremented write-back. A close
// beat walks the column word by word through a bit-serial divider (an
// empty document skips the divider and writes zero). A query beat streams
// the row out of the RAM, one cell per cycle. One item is in work at a
// time; a result sits in an output register, so the next item is taken
// while it waits to be read.
module term_frequency_engine
	import tfe_pkg::*;
#(
	parameter int WORD_COUNT  = WORD_COUNT_DEF,
	parameter int NUM_DOCS    = NUM_DOCS_DEF,
	parameter int MAX_DOC_LEN = MAX_DOC_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tfe_req_if.sink     req,
	tfe_rsp_if.source   rsp
);

	localparam int DEPTH = WORD_COUNT * NUM_DOCS;
	localparam int AW    = $clog2(DEPTH);
	localparam int WCW   = $clog2(WORD_COUNT);
	localparam int DCW   = $clog2(NUM_DOCS);

	localparam logic [3:0] ST_CLR     = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_WRD     = 4'd2;
	localparam logic [3:0] ST_CL_RD   = 4'd3;
	localparam logic [3:0] ST_CL_LD   = 4'd4;
	localparam logic [3:0] ST_CL_DIV  = 4'd5;
	localparam logic [3:0] ST_QRY     = 4'd6;
	localparam logic [3:0] ST_QRY_END = 4'd7;
	localparam logic [3:0] ST_FIN     = 4'd8;

	logic [3:0]        state_q;
	logic [AW-1:0]     addr_q;
	logic [WCW-1:0]    wcnt_q;
	logic [DCW-1:0]    dcnt_q;
	logic [LEN_W-1:0]  len_q;
	logic              sat_q;
	logic              ok_q;
	logic [1:0]        stat_q;
	logic [CELL_W-1:0] best_q;
	logic [DCW-1:0]    bdoc_q;
	logic              rd_vld_s1;
	logic [DCW-1:0]    rd_doc_s1;

	logic              out_vld_q;
	logic [1:0]        out_stat_q;
	logic [DCW-1:0]    out_doc_q;
	logic [CELL_W-1:0] out_tf_q;

	// Store
	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_data_q;
	logic [AW-1:0]     raddr;
	logic              mem_we;
	logic [CELL_W-1:0] mem_wdata;

	logic [AW-1:0]     in_addr;
	logic [AW-1:0]     row_base;
	logic              word_ok;
	logic              doc_ok;
	logic              accept;
	logic              len_full;
	logic              col_last;
	logic [DCW+3:0]    doc_ext;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign accept   = req.valid && req.ready;
	assign word_ok  = 32'(req.word_index) < WORD_COUNT;
	assign doc_ok   = 32'(req.doc_index) < NUM_DOCS;
	assign row_base = AW'(32'(req.word_index) * 32'(NUM_DOCS));
	assign in_addr  = row_base + AW'(req.doc_index);
	assign len_full = len_q >= LEN_W'(MAX_DOC_LEN);
	assign col_last = wcnt_q == WCW'(WORD_COUNT - 1);

	assign req.ready = state_q == ST_IDLE;
	assign raddr     = (state_q == ST_IDLE) ? in_addr : addr_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// Write port
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_WRD: begin
				mem_we    = ok_q && !len_full && (rd_data_q < CELL_MAX);
				mem_wdata = rd_data_q + 1'b1;
			end
			ST_CL_LD: begin
				mem_we = len_q == '0;
			end
			ST_CL_DIV: begin
				mem_we    = div_rsp.done;
				mem_wdata = div_rsp.quo;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign div_req.start = (state_q == ST_CL_LD) && (len_q != '0);
	assign div_req.tally = rd_data_q;
	assign div_req.len   = len_q;

	tfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			addr_q    <= '0;
			len_q     <= '0;
			sat_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= state_q == ST_QRY;
			// Output register: load on a finished item, drop once read
			if (state_q == ST_FIN && (!out_vld_q || rsp.ready)) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_WORD: begin
								addr_q  <= in_addr;
								state_q <= ST_WRD;
							end
							REQ_CLOSE: begin
								addr_q  <= AW'(req.doc_index);
								if (doc_ok) begin
									state_q <= ST_CL_RD;
								end else begin
									len_q   <= '0;
									sat_q   <= 1'b0;
									state_q <= ST_FIN;
								end
							end
							REQ_QUERY: begin
								addr_q  <= row_base;
								state_q <= word_ok ? ST_QRY : ST_FIN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WRD: begin
					state_q <= ST_IDLE;
					if (ok_q) begin
						if (len_full) begin
							sat_q <= 1'b1;
						end else begin
							len_q <= len_q + 1'b1;
							if (rd_data_q >= CELL_MAX) begin
								sat_q <= 1'b1;
							end
						end
					end
				end
				ST_CL_RD: begin
					state_q <= ST_CL_LD;
				end
				ST_CL_LD, ST_CL_DIV: begin
					if (state_q == ST_CL_LD && len_q != '0) begin
						state_q <= ST_CL_DIV;
					end else if (state_q == ST_CL_LD || div_rsp.done) begin
						if (col_last) begin
							len_q   <= '0;
							sat_q   <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							addr_q  <= addr_q + AW'(NUM_DOCS);
							state_q <= ST_CL_RD;
						end
					end
				end
				ST_QRY: begin
					addr_q <= addr_q + 1'b1;
					if (dcnt_q == DCW'(NUM_DOCS - 1)) begin
						state_q <= ST_QRY_END;
					end
				end
				ST_QRY_END: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_vld_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item bookkeeping and result fields
	always_ff @(posedge clk) begin
		rd_doc_s1 <= dcnt_q;
		if (accept) begin
			ok_q   <= word_ok && doc_ok;
			wcnt_q <= '0;
			dcnt_q <= '0;
			best_q <= '0;
			bdoc_q <= '0;
			if (req.req_type == REQ_CLOSE) begin
				if (len_q == '0) begin
					stat_q <= STAT_EMPTY;
				end else begin
					stat_q <= sat_q ? STAT_SAT : STAT_OK;
				end
			end else begin
				stat_q <= STAT_OK;
			end
		end
		if ((state_q == ST_CL_LD && len_q == '0) || (state_q == ST_CL_DIV && div_rsp.done)) begin
			wcnt_q <= wcnt_q + 1'b1;
		end
		if (state_q == ST_CL_DIV && div_rsp.done && div_rsp.clamp) begin
			stat_q <= STAT_SAT;
		end
		if (state_q == ST_QRY) begin
			dcnt_q <= dcnt_q + 1'b1;
		end
		// Running max over the row, lowest document wins ties
		if (rd_vld_s1 && (rd_doc_s1 == '0 || rd_data_q > best_q)) begin
			best_q <= rd_data_q;
			bdoc_q <= rd_doc_s1;
		end
		if (state_q == ST_FIN && (!out_vld_q || rsp.ready)) begin
			out_stat_q <= stat_q;
			out_doc_q  <= bdoc_q;
			out_tf_q   <= best_q;
		end
	end

	assign doc_ext      = {4'b0, out_doc_q};
	assign rsp.valid    = out_vld_q;
	assign rsp.status   = out_stat_q;
	assign rsp.best_doc = doc_ext[3:0];
	assign rsp.best_tf  = out_tf_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_DOC_LEN))
		else $error("document length above limit");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> addr_q <= AW'(DEPTH - 1))
		else $error("store write beyond depth");

	a_idle_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FIN) |-> !mem_we)
		else $error("store written outside an item");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRD && ok_q && len_full) |=> len_q == $past(len_q) && sat_q)
		else $error("dropped word changed the length");
`endif

endmodule
